[rtl/core/multichannel_input_debounce_core_assert.svh]
// Assertion macros for the debounce core checker.
`ifndef MULTICHANNEL_INPUT_DEBOUNCE_CORE_ASSERT_SVH
`define MULTICHANNEL_INPUT_DEBOUNCE_CORE_ASSERT_SVH

// Checked only while out of reset.
`define MDB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("debounce assertion failed");

// Checked at every edge, reset included.
`define MDB_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("debounce assertion failed");

`endif

[rtl/core/mdb_pkg.sv]
// Shared types and constants of the multichannel input debounce core.
package mdb_pkg;

  localparam int unsigned PinW    = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NarrowCh = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CfgThreshold = 2'd0,
    CfgMode      = 2'd1,
    CfgTarget    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeAll  = 2'd0,
    ModeLow  = 2'd1,
    ModeHigh = 2'd2
  } mode_e;

  typedef struct packed {
    logic [CountW-1:0] threshold;
    logic [1:0]        mode;
    logic [PinW-1:0]   target;
  } cfg_t;

endpackage

[rtl/core/mdb_cfg_regs.sv]
// Configuration register bank of the debounce core.
module mdb_cfg_regs
  import mdb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgThreshold: cfg_d.threshold = cfg_data_i;
        CfgMode:      cfg_d.mode      = cfg_data_i[1:0];
        CfgTarget:    cfg_d.target    = cfg_data_i;
        default:      cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/mdb_chan_filter.sv]
// One debounce channel: previous sample, repeat counter and filtered level.
module mdb_chan_filter
  import mdb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic              sample_i,
  input  logic [CountW-1:0] threshold_i,
  output logic              level_o
);

  logic              prev_q, prev_d;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_run;
  logic              level_q, level_d;

  always_comb begin
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    cnt_run = (sample_i == prev_q) ? cnt_q + CountW'(1) : '0;
    if (upd_i) begin
      prev_d = sample_i;
      cnt_d  = cnt_run;
      if (cnt_run >= threshold_i) begin
        level_d = sample_i;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      cnt_q   <= '0;
      level_q <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
    end
  end

  // Next level, so the result shows this sample's update.
  assign level_o = level_d;

endmodule

[rtl/core/multichannel_input_debounce_core.sv]
// Multichannel input debounce core: one pin sample in, one filtered result out per cycle,
// and a new request taken every cycle, while the result side keeps up; a sample passes
// from request to result through the input register, then the result register. The
// enabled channel filters update in parallel as a sample moves from the input register
// to the result register. Configuration writes are always accepted.
module multichannel_input_debounce_core
  import mdb_pkg::*;
#(
  parameter int unsigned CHANNELS       = 16,
  parameter int unsigned REGISTER_LIMIT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PinW-1:0]     pin_levels_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PinW-1:0]     raw_active_o,
  output logic [PinW-1:0]     filtered_word_o,
  output logic [IndexW-1:0]   register_index_o
);

  cfg_t cfg;

  logic            in_valid_q, in_valid_d;
  logic [PinW-1:0] pins_q;
  logic            out_valid_q, out_valid_d;
  logic [PinW-1:0] raw_q, filt_q;
  logic [IndexW-1:0] idx_q, idx_d;
  logic            in_accept, advance, wide, hi;
  logic [PinW-1:0] active;
  logic [CHANNELS-1:0] lane_en, lane_bit, lane_level, raw_lane, filt_lane;

  mdb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign active = ~pins_q;
  assign wide   = (cfg.mode == ModeAll);
  // Unused mode code reads the high pin byte, as the high mode does.
  assign hi     = (cfg.mode != ModeLow);

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    if (ch < NarrowCh) begin : g_low
      assign lane_en[ch]  = 1'b1;
      assign lane_bit[ch] = (!wide && hi) ? active[ch + NarrowCh] : active[ch];
    end else begin : g_upper
      assign lane_en[ch]  = wide;
      assign lane_bit[ch] = active[ch];
    end

    mdb_chan_filter u_filter (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .upd_i       (advance && lane_en[ch]),
      .sample_i    (lane_bit[ch]),
      .threshold_i (cfg.threshold),
      .level_o     (lane_level[ch])
    );
  end

  assign raw_lane  = lane_bit & lane_en;
  assign filt_lane = lane_level & lane_en;

  assign idx_d = ({1'b0, cfg.target} >= (CfgDataW + 1)'(REGISTER_LIMIT)) ?
                 '0 : cfg.target[IndexW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pins_q <= pin_levels_i;
    end
    if (advance) begin
      raw_q  <= PinW'(raw_lane);
      filt_q <= PinW'(filt_lane);
      idx_q  <= idx_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign raw_active_o     = raw_q;
  assign filtered_word_o  = filt_q;
  assign register_index_o = idx_q;

endmodule

[rtl/core/mdb_checker.sv]
// Port-level checker for the debounce core, bound to the top level.
`include "multichannel_input_debounce_core_assert.svh"

module mdb_checker
  import mdb_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PinW-1:0]     raw_active_o,
  input logic [PinW-1:0]     filtered_word_o,
  input logic [IndexW-1:0]   register_index_o
);

  `MDB_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  `MDB_ASSERT(a_result_holds, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(raw_active_o) &&
    $stable(filtered_word_o) && $stable(register_index_o))

  // Input side only backs up when a result is waiting and stalled.
  `MDB_ASSERT(a_stall_source, clk_i, rst_ni,
    in_stall_o |-> out_valid_o && out_stall_i)

  // An accepted request is followed by a valid result at the output.
  `MDB_ASSERT(a_request_reaches_out, clk_i, rst_ni,
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)

endmodule

bind multichannel_input_debounce_core mdb_checker u_mdb_checker (.*);
